[rtl/chst_pkg.sv]
// Shared constants for the chained hash symbol table: sizes, widths, status codes.
// Depends on nothing; used by chained_hash_symbol_table.
package chst_pkg;

  localparam int BUCKET_COUNT = 64;   // power of two, at most 256
  localparam int POOL_ENTRIES = 256;

  localparam int BUCKET_W = $clog2(BUCKET_COUNT);
  localparam int ENTRY_W  = $clog2(POOL_ENTRIES);
  localparam int USED_W   = $clog2(POOL_ENTRIES + 1);

  localparam int LETTER_W = 7;
  localparam int KEY_W    = 2 * LETTER_W;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  localparam logic [7:0] LETTER_BASE_X2 = 8'd130;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

[rtl/chained_hash_symbol_table.sv]
// Chained hash symbol table: two-letter keys, bucket chains in an entry pool.
// A search visits the chain entries of its bucket; a new insert then allocates and links an entry.
// One request at a time: in_ready is low until the result is loaded.
// The sequencer walks one chain entry per cycle through the entry RAM read port.
// Reset (rst_n, synchronous) empties all buckets and the pool counter at once;
// entry RAMs are not cleared. Depends on chst_pkg and chst_ram.
module chained_hash_symbol_table (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_cmd,
  input  logic [chst_pkg::LETTER_W-1:0]           in_key_first_letter,
  input  logic [chst_pkg::LETTER_W-1:0]           in_key_second_letter,
  input  logic signed [chst_pkg::VALUE_W-1:0]     in_insert_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [chst_pkg::STATUS_W-1:0]           out_status,
  output logic signed [chst_pkg::VALUE_W-1:0]     out_found_value
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam int EW = chst_pkg::ENTRY_W;

  logic [2:0]                          state_r, state_nxt;
  logic [chst_pkg::USED_W-1:0]         used_r, used_nxt;
  logic [chst_pkg::BUCKET_COUNT-1:0]   head_valid_r;
  logic                                cmd_r;
  logic [chst_pkg::KEY_W-1:0]          key_r;
  logic [chst_pkg::VALUE_W-1:0]        value_r;
  logic [chst_pkg::BUCKET_W-1:0]       bucket_r;
  logic                                hv_r;
  logic [EW-1:0]                       cur_r;
  logic [chst_pkg::STATUS_W-1:0]       res_status_r;
  logic [chst_pkg::VALUE_W-1:0]        res_value_r;
  logic                                out_valid_r;
  logic [chst_pkg::STATUS_W-1:0]       out_status_r;
  logic [chst_pkg::VALUE_W-1:0]        out_value_r;

  logic                                in_beat, out_load;
  logic [7:0]                          sum8;
  logic [chst_pkg::BUCKET_W-1:0]       bucket_in;

  logic [EW-1:0]                       head_rd;
  logic [chst_pkg::KEY_W-1:0]          key_rd;
  logic [chst_pkg::VALUE_W-1:0]        payload_rd;
  logic [EW:0]                         link_rd;   // {valid, next entry}

  logic                                ent_rd_en;
  logic [EW-1:0]                       ent_rd_addr;
  logic                                head_we, ent_we, link_we;
  logic [EW-1:0]                       link_wr_addr;
  logic [EW:0]                         link_wr_data;
  logic [EW-1:0]                       new_idx;

  logic                                key_hit;
  logic                                can_alloc;
  logic [chst_pkg::STATUS_W-1:0]       miss_status;

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // Wrapped 8-bit letter sum; the bucket count is a power of two, so the low bits reduce it.
  assign sum8      = 8'(in_key_first_letter) + 8'(in_key_second_letter)
                   - chst_pkg::LETTER_BASE_X2;
  assign bucket_in = sum8[chst_pkg::BUCKET_W-1:0];

  assign new_idx     = used_r[EW-1:0];
  assign key_hit     = (key_rd == key_r);
  assign can_alloc   = (used_r < chst_pkg::USED_W'(chst_pkg::POOL_ENTRIES));
  assign miss_status = cmd_r ? chst_pkg::ST_NOT_FOUND : chst_pkg::ST_FULL;

  assign ent_rd_en   = ((state_r == S_HEAD) && hv_r)
                    || ((state_r == S_CMP) && !key_hit && link_rd[EW]);
  assign ent_rd_addr = (state_r == S_HEAD) ? head_rd : link_rd[EW-1:0];

  assign head_we      = (state_r == S_LINK) && !hv_r;
  assign ent_we       = (state_r == S_ALLOC);
  assign link_we      = ent_we || ((state_r == S_LINK) && hv_r);
  assign link_wr_addr = ent_we ? new_idx : cur_r;
  assign link_wr_data = ent_we ? {1'b0, {EW{1'b0}}} : {1'b1, new_idx};

  chst_ram #(.DEPTH(chst_pkg::BUCKET_COUNT), .WIDTH(EW)) u_head_ram (
    .clk     (clk),
    .we      (head_we),
    .wr_addr (bucket_r),
    .wr_data (new_idx),
    .rd_en   (in_beat),
    .rd_addr (bucket_in),
    .rd_data (head_rd)
  );

  chst_ram #(.DEPTH(chst_pkg::POOL_ENTRIES), .WIDTH(chst_pkg::KEY_W)) u_key_ram (
    .clk     (clk),
    .we      (ent_we),
    .wr_addr (new_idx),
    .wr_data (key_r),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (key_rd)
  );

  chst_ram #(.DEPTH(chst_pkg::POOL_ENTRIES), .WIDTH(chst_pkg::VALUE_W)) u_payload_ram (
    .clk     (clk),
    .we      (ent_we),
    .wr_addr (new_idx),
    .wr_data (value_r),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (payload_rd)
  );

  chst_ram #(.DEPTH(chst_pkg::POOL_ENTRIES), .WIDTH(EW + 1)) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (link_rd)
  );

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (hv_r) begin
          state_nxt = S_CMP;
        end else if (!cmd_r && can_alloc) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CMP: begin
        if (key_hit) begin
          state_nxt = S_RESP;
        end else if (link_rd[EW]) begin
          state_nxt = S_CMP;
        end else if (!cmd_r && can_alloc) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_ALLOC: begin
        state_nxt = S_LINK;
      end
      S_LINK: begin
        used_nxt  = used_r + 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      head_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (head_we) begin
        head_valid_r[bucket_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r    <= in_cmd;
      key_r    <= {in_key_first_letter, in_key_second_letter};
      value_r  <= in_insert_value;
      bucket_r <= bucket_in;
      hv_r     <= head_valid_r[bucket_in];
    end
    case (state_r)
      S_HEAD: begin
        cur_r        <= head_rd;
        res_status_r <= miss_status;
        res_value_r  <= '0;
      end
      S_CMP: begin
        if (key_hit) begin
          res_status_r <= cmd_r ? chst_pkg::ST_FOUND : chst_pkg::ST_DUPLICATE;
          res_value_r  <= cmd_r ? payload_rd : '0;
        end else if (link_rd[EW]) begin
          // advance to the next entry of the chain
          cur_r <= link_rd[EW-1:0];
        end
      end
      S_LINK: begin
        res_status_r <= chst_pkg::ST_INSERTED;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= chst_pkg::USED_W'(chst_pkg::POOL_ENTRIES))
    else $error("pool counter past pool size");

  a_link_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |=> (used_r == $past(used_r) + 1'b1))
    else $error("insert did not advance pool counter");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != chst_pkg::ST_FOUND)) |-> (out_value_r == '0))
    else $error("nonzero value on a beat that is not found");

  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> (can_alloc && !cmd_r))
    else $error("allocation without room or on search");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= chst_pkg::ST_FULL))
    else $error("status code out of range");

endmodule

[rtl/chst_ram.sv]
// Generic single-clock RAM: one write port, one registered read port with enable.
// No dependencies.
module chst_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
